FILE: src/mtr_pkg.sv
// Shared types, constants and helpers for the top-1 capacity router.
// No dependencies; used by every module in src.
`default_nettype none
package mtr_pkg;
  localparam int EXPERT_CNT  = 8;
  localparam int LOGIT_WIDTH = 16;
  localparam int MAX_BATCH   = 4096;
  localparam int EXP_IDX_W   = $clog2(EXPERT_CNT);
  localparam int CNT_W       = $clog2(MAX_BATCH + 1);
  localparam int SLOT_W      = 12;
  localparam int GATE_W      = 16;
  localparam int TERM_W      = 17;
  localparam int SUM_W       = TERM_W + EXP_IDX_W;
  localparam int DIFF_W      = LOGIT_WIDTH + 1;
  localparam int NDX_W       = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(40);

  // exp(-1/256) in Q2.62, truncated alternating series
  localparam logic [63:0] Q62_ONE = 64'd1 << 62;
  localparam logic [63:0] EXP_T1 = 64'd1 << 54;
  localparam logic [63:0] EXP_T2 = 64'd1 << 45;
  localparam logic [63:0] EXP_T3 = (64'd1 << 38) / 64'd6;
  localparam logic [63:0] EXP_T4 = (64'd1 << 30) / 64'd24;
  localparam logic [63:0] EXP_T5 = (64'd1 << 22) / 64'd120;
  localparam logic [63:0] EXP_T6 = (64'd1 << 14) / 64'd720;
  localparam logic [63:0] EXP_BASE =
    Q62_ONE - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4 - EXP_T5 + EXP_T6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPERTS = 2'd0,
    CFG_BATCH   = 2'd1,
    CFG_FACTOR  = 2'd2,
    CFG_NONE    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ARG, ST_LANE_GO, ST_LANE_WAIT, ST_DIV_GO, ST_DIV_WAIT, ST_OUT
  } rtr_state_e;

  typedef struct packed {
    logic             start;
    logic             far;
    logic [NDX_W-1:0] n;
  } lane_cmd_t;

  function automatic logic [EXP_IDX_W:0] clamp_experts(input logic [3:0] e);
    logic [EXP_IDX_W:0] r;
    if (e == 4'd0) r = (EXP_IDX_W+1)'(1);
    else if (e > 4'(EXPERT_CNT)) r = (EXP_IDX_W+1)'(EXPERT_CNT);
    else r = (EXP_IDX_W+1)'(e);
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: src/mtr_exp_lane.sv
// One lane: round(65536*exp(-n/256)) by square-and-multiply in Q2.62.
// Uses mtr_pkg; one 32x32 multiplier, 64x64 products built from four partial products.
`default_nettype none
module mtr_exp_lane import mtr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lane_cmd_t         cmd_i,
  output logic                   busy_o,
  output logic [TERM_W-1:0]      term_o
);
  logic              busy_q, busy_d;
  logic              far_q, far_d;
  logic [NDX_W-1:0]  n_q, n_d;
  logic [3:0]        k_q, k_d;
  logic [3:0]        ph_q, ph_d;
  logic [63:0]       p_q, p_d, base_q, base_d;
  logic [127:0]      acc_q, acc_d;
  logic [TERM_W-1:0] term_q, term_d;
  logic [63:0]       opa, opb;
  logic [31:0]       ma, mb;
  logic [63:0]       part;
  logic [127:0]      rnd_sum;
  logic [63:0]       rnd;
  logic [63:0]       fin;
  logic [1:0]        sel;

  always_comb begin
    if (ph_q < 4'd5) begin
      opa = p_q;
      sel = ph_q[1:0];
    end else begin
      opa = base_q;
      sel = 2'(ph_q - 4'd5);
    end
    opb = base_q;
    ma  = sel[1] ? opa[63:32] : opa[31:0];
    mb  = sel[0] ? opb[63:32] : opb[31:0];
    part = 64'(ma) * 64'(mb);
    rnd_sum = acc_q + (128'd1 << 61);
    rnd = rnd_sum[125:62];
    fin = p_q + (64'd1 << 45);
  end

  always_comb begin
    busy_d = busy_q;
    far_d  = far_q;
    n_d    = n_q;
    k_d    = k_q;
    ph_d   = ph_q;
    p_d    = p_q;
    base_d = base_q;
    acc_d  = acc_q;
    term_d = term_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      far_d  = cmd_i.far;
      n_d    = cmd_i.n;
      k_d    = 4'd0;
      ph_d   = 4'd0;
      p_d    = Q62_ONE;
      base_d = EXP_BASE;
      acc_d  = '0;
    end else if (busy_q) begin
      ph_d = ph_q + 4'd1;
      case (ph_q)
        4'd4: begin
          if (n_q[k_q]) p_d = rnd;
          acc_d = '0;
        end
        4'd9: begin
          base_d = rnd;
          acc_d  = '0;
          ph_d   = 4'd0;
          k_d    = k_q + 4'd1;
          if (k_q == 4'(NDX_W - 1)) begin
            busy_d = 1'b0;
            term_d = far_q ? '0 : fin[62:46];
          end
        end
        default: begin
          case (sel)
            2'd0:    acc_d = acc_q + 128'(part);
            2'd3:    acc_d = acc_q + (128'(part) << 64);
            default: acc_d = acc_q + (128'(part) << 32);
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
      ph_q   <= '0;
    end else begin
      busy_q <= busy_d;
      k_q    <= k_d;
      ph_q   <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    far_q  <= far_d;
    n_q    <= n_d;
    p_q    <= p_d;
    base_q <= base_d;
    acc_q  <= acc_d;
    term_q <= term_d;
  end

  assign busy_o = busy_q;
  assign term_o = term_q;
endmodule
`default_nettype wire

FILE: src/mtr_gate_div.sv
// Restoring divider for gate = min(65535, floor(2^32 / S)), one bit a cycle.
// Uses mtr_pkg; S is at least 2^16 so the quotient fits 17 bits.
`default_nettype none
module mtr_gate_div import mtr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SUM_W-1:0] sum_i,
  output logic                  busy_o,
  output logic [GATE_W-1:0]     gate_o
);
  logic             busy_q, busy_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [SUM_W:0]   rem_q, rem_d;
  logic [SUM_W-1:0] den_q, den_d;
  logic [16:0]      quo_q, quo_d;
  logic [SUM_W:0]   sh;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    sh     = {rem_q[SUM_W-1:0], 1'b0};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = (SUM_W+1)'(1) << 15;
      den_d  = sum_i;
      quo_d  = '0;
    end else if (busy_q) begin
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q};
        quo_d = {quo_q[15:0], 1'b1};
      end else begin
        rem_d = sh;
        quo_d = {quo_q[15:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd16) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign gate_o = quo_q[16] ? '1 : quo_q[15:0];
endmodule
`default_nettype wire

FILE: src/mtr_cap_calc.sv
// Capacity derivation: ceil(batch/E) by restoring division, then factor scaling.
// Uses mtr_pkg; restarts on each configuration write except to CFG_NONE.
`default_nettype none
module mtr_cap_calc import mtr_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [3:0]            experts_i,
  input  wire logic [12:0]           batch_i,
  input  wire logic [11:0]           factor_i,
  output logic                       busy_o,
  output logic [CNT_W-1:0]           cap_o
);
  logic               busy_q, busy_d;
  logic [3:0]         cnt_q, cnt_d;
  logic [13:0]        num_q, num_d;
  logic [3:0]         rem_q, rem_d;
  logic [3:0]         den_q, den_d;
  logic [11:0]        fac_q, fac_d;
  logic [CNT_W-1:0]   cap_q, cap_d;
  logic [4:0]         sh;
  logic [EXP_IDX_W:0] e_cl;
  logic [25:0]        prod;
  logic [17:0]        scaled;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    fac_d  = fac_q;
    cap_d  = cap_q;
    e_cl   = clamp_experts(experts_i);
    sh     = {rem_q, num_q[13]};
    prod   = 26'(num_q) * 26'(fac_q);
    scaled = 18'((prod + 26'd255) >> 8);
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = 14'(batch_i) + 14'(e_cl) - 14'd1;
      rem_d  = '0;
      den_d  = 4'(e_cl);
      fac_d  = factor_i;
    end else if (busy_q) begin
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd14) begin
        busy_d = 1'b0;
        if (scaled == 18'd0) cap_d = CNT_W'(1);
        else if (scaled > 18'(MAX_BATCH)) cap_d = CNT_W'(MAX_BATCH);
        else cap_d = CNT_W'(scaled);
      end else if (sh >= {1'b0, den_q}) begin
        rem_d = 4'(sh - {1'b0, den_q});
        num_d = {num_q[12:0], 1'b1};
      end else begin
        rem_d = sh[3:0];
        num_d = {num_q[12:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      cap_q  <= CAP_RESET;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      cap_q  <= cap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    fac_q <= fac_d;
  end

  assign busy_o = busy_q;
  assign cap_o  = cap_q;
endmodule
`default_nettype wire

FILE: src/moe_top1_capacity_router.sv
// Top-1 capacity router: argmax, per-expert slot counts, softmax gate lanes.
// Uses mtr_pkg, mtr_exp_lane, mtr_gate_div and mtr_cap_calc.
//
//  channel | direction | handshake         | beat
//  in      | to block  | in_valid/in_stall | logits, first_of_batch
//  out     | from block| out_valid/out_stall | expert, slot, dropped, gate
//  cfg     | to block  | cfg_valid/cfg_ready | register index, data
//
// One item is processed at a time: a new beat is taken only after the item has
// passed the exp lanes (12 square-and-multiply steps on one 32x32 multiplier
// per lane), the gate divider and the state handoffs back to idle. After a
// register write other than to CFG_NONE, input stalls while capacity is
// recomputed. The next item is taken while a result waits on a stalled output.
`default_nettype none
module moe_top1_capacity_router import mtr_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [LOGIT_WIDTH-1:0] logit_0_i,
  input  wire logic signed [LOGIT_WIDTH-1:0] logit_1_i,
  input  wire logic signed [LOGIT_WIDTH-1:0] logit_2_i,
  input  wire logic signed [LOGIT_WIDTH-1:0] logit_3_i,
  input  wire logic signed [LOGIT_WIDTH-1:0] logit_4_i,
  input  wire logic signed [LOGIT_WIDTH-1:0] logit_5_i,
  input  wire logic signed [LOGIT_WIDTH-1:0] logit_6_i,
  input  wire logic signed [LOGIT_WIDTH-1:0] logit_7_i,
  input  wire logic                          first_of_batch_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [EXP_IDX_W-1:0]               chosen_expert_o,
  output logic [SLOT_W-1:0]                  slot_o,
  output logic                               dropped_o,
  output logic [GATE_W-1:0]                  gate_prob_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data_i
);
  rtr_state_e state_q, state_d;

  logic [3:0]  experts_q;
  logic [12:0] batch_q;
  logic [11:0] factor_q;
  logic        cfg_we;
  logic        cap_busy;
  logic [CNT_W-1:0] cap;

  logic signed [LOGIT_WIDTH-1:0] logit_q [EXPERT_CNT];
  logic        first_q;
  logic [EXP_IDX_W-1:0] best_q, best_c;
  logic signed [LOGIT_WIDTH-1:0] max_q, max_c;
  logic [EXP_IDX_W:0]  e_cnt;
  logic [CNT_W-1:0]    cnt_q [EXPERT_CNT];
  logic [CNT_W-1:0]    cur_cnt;
  logic [SLOT_W-1:0]   slot_q;
  logic                drop_q;
  logic [SUM_W-1:0]    sum_q, sum_c;

  lane_cmd_t           cmd [EXPERT_CNT];
  logic [EXPERT_CNT-1:0] lane_busy;
  logic [TERM_W-1:0]   term [EXPERT_CNT];
  logic                div_busy;
  logic [GATE_W-1:0]   gate;

  logic in_acc, lane_go, div_go, cnt_upd, out_load;

  logic                 out_valid_q;
  logic [EXP_IDX_W-1:0] out_exp_q;
  logic [SLOT_W-1:0]    out_slot_q;
  logic                 out_drop_q;
  logic [GATE_W-1:0]    out_gate_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign e_cnt       = clamp_experts(experts_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      experts_q <= 4'd8;
      batch_q   <= 13'd256;
      factor_q  <= 12'd320;
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_EXPERTS: experts_q <= cfg_data_i[3:0];
        CFG_BATCH:   batch_q   <= cfg_data_i;
        CFG_FACTOR:  factor_q  <= cfg_data_i[11:0];
        default:     ;
      endcase
    end
  end

  mtr_cap_calc u_cap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cfg_we && cfg_idx_e'(cfg_index_i) != CFG_NONE),
    .experts_i (cfg_idx_e'(cfg_index_i) == CFG_EXPERTS ? cfg_data_i[3:0] : experts_q),
    .batch_i   (cfg_idx_e'(cfg_index_i) == CFG_BATCH ? cfg_data_i : batch_q),
    .factor_i  (cfg_idx_e'(cfg_index_i) == CFG_FACTOR ? cfg_data_i[11:0] : factor_q),
    .busy_o    (cap_busy),
    .cap_o     (cap)
  );

  assign in_stall_o = (state_q != ST_IDLE) || cap_busy;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    best_c = '0;
    max_c  = logit_q[0];
    for (int e = 1; e < EXPERT_CNT; e++) begin
      if ((EXP_IDX_W+1)'(e) < e_cnt && logit_q[e] > max_c) begin
        best_c = EXP_IDX_W'(e);
        max_c  = logit_q[e];
      end
    end
  end

  always_comb begin
    logic signed [DIFF_W-1:0] d;
    for (int e = 0; e < EXPERT_CNT; e++) begin
      d = DIFF_W'(max_q) - DIFF_W'(logit_q[e]);
      cmd[e].start = lane_go;
      cmd[e].far   = (d > DIFF_W'(4095));
      cmd[e].n     = d[NDX_W-1:0];
    end
  end

  for (genvar g = 0; g < EXPERT_CNT; g++) begin : g_lane
    mtr_exp_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd[g]),
      .busy_o (lane_busy[g]),
      .term_o (term[g])
    );
  end

  always_comb begin
    sum_c = '0;
    for (int e = 0; e < EXPERT_CNT; e++) begin
      if ((EXP_IDX_W+1)'(e) < e_cnt) sum_c = sum_c + SUM_W'(term[e]);
    end
  end

  mtr_gate_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .sum_i   (sum_q),
    .busy_o  (div_busy),
    .gate_o  (gate)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_acc) state_d = ST_ARG;
      ST_ARG:       state_d = ST_LANE_GO;
      ST_LANE_GO:   state_d = ST_LANE_WAIT;
      ST_LANE_WAIT: if (lane_busy == '0) state_d = ST_DIV_GO;
      ST_DIV_GO:    state_d = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (!div_busy) state_d = ST_OUT;
      ST_OUT:       if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    lane_go  = (state_q == ST_LANE_GO);
    cnt_upd  = (state_q == ST_LANE_GO);
    div_go   = (state_q == ST_DIV_GO);
    out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  end

  assign cur_cnt = first_q ? '0 : cnt_q[best_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int e = 0; e < EXPERT_CNT; e++) cnt_q[e] <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (cnt_upd) begin
        for (int e = 0; e < EXPERT_CNT; e++) begin
          if (EXP_IDX_W'(e) == best_q && cur_cnt < cap) cnt_q[e] <= cur_cnt + CNT_W'(1);
          else if (first_q) cnt_q[e] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      logit_q[0] <= logit_0_i;
      logit_q[1] <= logit_1_i;
      logit_q[2] <= logit_2_i;
      logit_q[3] <= logit_3_i;
      logit_q[4] <= logit_4_i;
      logit_q[5] <= logit_5_i;
      logit_q[6] <= logit_6_i;
      logit_q[7] <= logit_7_i;
      first_q    <= first_of_batch_i;
    end
    if (state_q == ST_ARG) begin
      best_q <= best_c;
      max_q  <= max_c;
    end
    if (cnt_upd) begin
      drop_q <= !(cur_cnt < cap);
      slot_q <= (cur_cnt < cap) ? cur_cnt[SLOT_W-1:0] : '0;
    end
    if (div_go == 1'b0 && state_q == ST_LANE_WAIT) sum_q <= sum_c;
    if (out_load) begin
      out_exp_q  <= best_q;
      out_slot_q <= slot_q;
      out_drop_q <= drop_q;
      out_gate_q <= gate;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chosen_expert_o = out_exp_q;
  assign slot_o          = out_slot_q;
  assign dropped_o       = out_drop_q;
  assign gate_prob_o     = out_gate_q;
endmodule
`default_nettype wire

FILE: sim/moe_top1_capacity_router_tb.sv
// Self-checking bench for moe_top1_capacity_router: directed rows, then random
// phases under several register settings, checked against a bit-exact predictor.
// Depends on src/mtr_pkg.sv and the RTL of the router.
`timescale 1ns / 1ps
module moe_top1_capacity_router_tb;
  import mtr_pkg::*;

  localparam int RUN_LIMIT = 3000000;

  typedef struct packed {
    logic [EXPERT_CNT-1:0][LOGIT_WIDTH-1:0] lg;
    logic                                    fob;
  } token_t;

  typedef struct packed {
    logic [EXP_IDX_W-1:0] expert;
    logic [SLOT_W-1:0]    slot;
    logic                 dropped;
    logic [GATE_W-1:0]    gate;
  } route_t;

  typedef struct packed {
    token_t tok;
    logic   typed;
    route_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic [EXPERT_CNT-1:0][LOGIT_WIDTH-1:0] lg_drv = '0;
  logic fob_drv = 1'b0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_EXPERTS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  wire in_stall, out_valid, cfg_ready, dropped;
  wire [EXP_IDX_W-1:0] chosen_expert;
  wire [SLOT_W-1:0] slot;
  wire [GATE_W-1:0] gate_prob;

  moe_top1_capacity_router u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .logit_0_i(lg_drv[0]), .logit_1_i(lg_drv[1]), .logit_2_i(lg_drv[2]),
    .logit_3_i(lg_drv[3]), .logit_4_i(lg_drv[4]), .logit_5_i(lg_drv[5]),
    .logit_6_i(lg_drv[6]), .logit_7_i(lg_drv[7]),
    .first_of_batch_i(fob_drv),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .chosen_expert_o(chosen_expert), .slot_o(slot), .dropped_o(dropped),
    .gate_prob_o(gate_prob),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // predictor state
  logic [3:0]       m_experts = 4'd8;
  logic [12:0]      m_batch = 13'd256;
  logic [11:0]      m_factor = 12'd320;
  logic [12:0]      m_counts [EXPERT_CNT];
  logic [12:0]      m_cap = 13'd40;
  route_t           route_q [$];
  int               n_err = 0;
  int               cycles = 0;
  int               burst_left = 0;

  function automatic int active_experts();
    int e;
    e = m_experts;
    if (e < 1) e = 1;
    if (e > EXPERT_CNT) e = EXPERT_CNT;
    return e;
  endfunction

  function automatic logic [12:0] capacity_of();
    longint e, uni, cap;
    e = active_experts();
    uni = (longint'(m_batch) + e - 1) / e;
    cap = (uni * m_factor + 255) >>> 8;
    if (cap < 1) cap = 1;
    if (cap > MAX_BATCH) cap = MAX_BATCH;
    return 13'(cap);
  endfunction

  function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b} + (128'd1 << 61);
    return p[125:62];
  endfunction

  // round(65536 * exp(-n/256)), zero beyond 4095
  function automatic logic [63:0] exp_weight(longint n);
    logic [63:0] term, base, p;
    term = 64'd1 << 62;
    base = term;
    p = term;
    if (n > 4095) return 64'd0;
    for (int i = 1; i <= 10; i++) begin
      term = term / (64'd256 * i);
      if (i % 2) base = base - term;
      else base = base + term;
    end
    for (int k = 0; k < 12; k++) begin
      if ((n >> k) & 1) p = q62_mul(p, base);
      base = q62_mul(base, base);
    end
    return (p + (64'd1 << 45)) >> 46;
  endfunction

  function automatic route_t route_token(token_t t);
    route_t r;
    int ec, best;
    logic signed [LOGIT_WIDTH-1:0] l [EXPERT_CNT];
    logic [63:0] sum, g;
    ec = active_experts();
    best = 0;
    sum = 0;
    for (int e = 0; e < EXPERT_CNT; e++) l[e] = t.lg[e];
    if (t.fob) for (int e = 0; e < EXPERT_CNT; e++) m_counts[e] = '0;
    for (int e = 1; e < ec; e++) if (l[e] > l[best]) best = e;
    for (int e = 0; e < ec; e++) sum += exp_weight(longint'(l[best]) - longint'(l[e]));
    g = (64'd1 << 32) / sum;
    if (g > 65535) g = 65535;
    r.expert = EXP_IDX_W'(best);
    r.gate = g[GATE_W-1:0];
    if (m_counts[best] < m_cap) begin
      r.slot = m_counts[best][SLOT_W-1:0];
      r.dropped = 1'b0;
      m_counts[best] = m_counts[best] + 1;
    end else begin
      r.slot = '0;
      r.dropped = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    n_err++;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("moe_top1_capacity_router: mismatch");
      $finish;
    end
  end

  // receiver: stall pattern changes mode every so often
  int stall_pct = 0, stall_hold = 0;
  always @(posedge clk_i) begin
    if (stall_hold == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 30;
        2: stall_pct = 80;
        default: stall_pct = 97;
      endcase
      stall_hold = $urandom_range(20, 600);
    end else begin
      stall_hold--;
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    route_t w;
    if (rst_ni && out_valid && !out_stall) begin
      if (route_q.size() == 0) begin
        report_mismatch("unexpected beat, expert", chosen_expert, -1);
      end else begin
        w = route_q.pop_front();
        if (chosen_expert !== w.expert) report_mismatch("chosen_expert", chosen_expert, w.expert);
        if (slot !== w.slot) report_mismatch("slot", slot, w.slot);
        if (dropped !== w.dropped) report_mismatch("dropped", dropped, w.dropped);
        if (gate_prob !== w.gate) report_mismatch("gate_prob", gate_prob, w.gate);
      end
    end
  end

  task automatic send_token(token_t t, logic typed, route_t want);
    route_t p;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    lg_drv <= t.lg;
    fob_drv <= t.fob;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    p = route_token(t);
    route_q.insert(route_q.size(), typed ? want : p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (route_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_EXPERTS: m_experts = d[3:0];
      CFG_BATCH:   m_batch = d[12:0];
      CFG_FACTOR:  m_factor = d[11:0];
      default: ;
    endcase
    m_cap = capacity_of();
    @(posedge clk_i);
  endtask

  function automatic token_t flat_token(int v, logic fob);
    token_t t;
    for (int e = 0; e < EXPERT_CNT; e++) t.lg[e] = LOGIT_WIDTH'(v);
    t.fob = fob;
    return t;
  endfunction

  function automatic row_t mk_row(token_t t, logic typed, int ex, int sl, int dr, int g);
    row_t r;
    r.tok = t;
    r.typed = typed;
    r.res.expert = EXP_IDX_W'(ex);
    r.res.slot = SLOT_W'(sl);
    r.res.dropped = dr[0];
    r.res.gate = GATE_W'(g);
    return r;
  endfunction

  function automatic token_t rand_token();
    token_t t;
    int base, v;
    base = $urandom_range(0, 65535) - 32768;
    for (int e = 0; e < EXPERT_CNT; e++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: v = $urandom_range(0, 65535) - 32768;
        3: v = base;
        4: v = ($urandom_range(0, 1)) ? 32767 : -32768;
        default: v = base - $urandom_range(0, 1500);
      endcase
      if (v < -32768) v = -32768;
      t.lg[e] = LOGIT_WIDTH'(v);
    end
    t.fob = ($urandom_range(0, 29) == 0);
    return t;
  endfunction

  row_t dir_tab [12];

  initial begin
    token_t t;
    for (int e = 0; e < EXPERT_CNT; e++) m_counts[e] = '0;
    dir_tab[0] = mk_row(flat_token(0, 1'b0), 1'b1, 0, 0, 0, 8192);
    dir_tab[1] = mk_row(flat_token(0, 1'b0), 1'b1, 0, 1, 0, 8192);
    t = flat_token(-32768, 1'b1);
    t.lg[7] = 16'h7fff;
    dir_tab[2] = mk_row(t, 1'b1, 7, 0, 0, 65535);
    dir_tab[3] = mk_row(flat_token(-32768, 1'b0), 1'b1, 0, 0, 0, 8192);
    dir_tab[4] = mk_row(flat_token(32767, 1'b0), 1'b1, 0, 1, 0, 8192);
    for (int e = 0; e < EXPERT_CNT; e++) t.lg[e] = (e % 2) ? 16'h5555 : 16'haaaa;
    t.fob = 1'b0;
    dir_tab[5] = mk_row(t, 1'b0, 0, 0, 0, 0);
    t = flat_token(0, 1'b0);
    t.lg[3] = 16'd100;
    t.lg[5] = 16'd100;
    dir_tab[6] = mk_row(t, 1'b0, 0, 0, 0, 0);
    for (int e = 0; e < EXPERT_CNT; e++) t.lg[e] = LOGIT_WIDTH'(e);
    dir_tab[7] = mk_row(t, 1'b0, 0, 0, 0, 0);
    t = flat_token(-32768, 1'b0);
    t.lg[0] = 16'd0;
    t.lg[1] = -16'sd4095;
    t.lg[2] = -16'sd4096;
    dir_tab[8] = mk_row(t, 1'b0, 0, 0, 0, 0);
    // capacity 1 after batch 0
    dir_tab[9] = mk_row(flat_token(0, 1'b1), 1'b1, 0, 0, 0, 8192);
    dir_tab[10] = mk_row(flat_token(0, 1'b0), 1'b1, 0, 0, 1, 8192);
    // one expert considered
    t = flat_token(0, 1'b1);
    t.lg[1] = 16'h7fff;
    dir_tab[11] = mk_row(t, 1'b1, 0, 0, 0, 65535);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (20) @(posedge clk_i);

    for (int i = 0; i < 12; i++) begin
      if (i == 9) begin
        drain();
        cfg_write(CFG_BATCH, 13'd0);
      end
      if (i == 11) begin
        drain();
        cfg_write(CFG_EXPERTS, 13'd0);
      end
      send_token(dir_tab[i].tok, dir_tab[i].typed, dir_tab[i].res);
    end

    for (int ph = 0; ph < 14; ph++) begin
      drain();
      if (ph < 3) begin
        cfg_write(CFG_EXPERTS, (ph == 0) ? 13'd15 : (ph == 1) ? 13'd8 : 13'd1);
        cfg_write(CFG_BATCH, (ph == 2) ? 13'd4096 : 13'd8191);
        cfg_write(CFG_FACTOR, (ph == 1) ? 13'd1 : 13'd4095);
      end else begin
        if ($urandom_range(0, 1)) cfg_write(CFG_EXPERTS, 13'($urandom_range(0, 8191)));
        if ($urandom_range(0, 1)) cfg_write(CFG_BATCH, 13'($urandom_range(0, 80)));
        if ($urandom_range(0, 1)) cfg_write(CFG_FACTOR, 13'($urandom_range(0, 1023)));
        if ($urandom_range(0, 3) == 0) cfg_write(CFG_BATCH, 13'($urandom_range(0, 8191)));
        if ($urandom_range(0, 2) == 0) cfg_write(CFG_FACTOR, 13'($urandom_range(1, 4095)));
      end
      if ($urandom_range(0, 2) == 0) cfg_write(CFG_NONE, 13'($urandom_range(0, 8191)));
      repeat (90) send_token(rand_token(), 1'b0, '0);
    end

    drain();
    repeat (300) @(posedge clk_i);
    if (n_err == 0 && route_q.size() == 0) begin
      $display("moe_top1_capacity_router: match");
    end else begin
      $display("moe_top1_capacity_router: mismatch");
    end
    $finish;
  end
endmodule

FILE: moe_top1_capacity_router.f
src/mtr_pkg.sv
src/mtr_exp_lane.sv
src/mtr_gate_div.sv
src/mtr_cap_calc.sv
src/moe_top1_capacity_router.sv
sim/moe_top1_capacity_router_tb.sv
